FILE: sv/pqd_pkg.sv
// Package for the process queue: record type, opcodes, status codes and the
// broadcast control struct shared by the queue cells. No dependencies.
`timescale 1ns / 1ps

package pqd_pkg;

    localparam logic [1:0] OP_PUSH     = 2'd0;
    localparam logic [1:0] OP_POP      = 2'd1;
    localparam logic [1:0] OP_DEL_ID   = 2'd2;
    localparam logic [1:0] OP_DEL_NAME = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [15:0] id;
        logic [7:0]  priority_v;
        logic [15:0] runtime;
        logic [63:0] name;
    } t_rec;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic        cmp_en;
        logic [1:0]  op;
        logic [15:0] key_id;
        logic [63:0] key_name;
        t_rec        load_rec;
    } t_cell_bcast;

endpackage

FILE: sv/pqd_if.sv
// Handshake channels for the process queue: input operation and result.
// Depends on nothing; valid/ready with payload, source and sink modports.
`timescale 1ns / 1ps

interface pqd_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [15:0] proc_id;
    logic [7:0]  proc_priority;
    logic [15:0] proc_runtime;
    logic [63:0] proc_name;

    modport source (output valid, opcode, proc_id, proc_priority, proc_runtime, proc_name,
                    input ready);
    modport sink   (input valid, opcode, proc_id, proc_priority, proc_runtime, proc_name,
                    output ready);
endinterface

interface pqd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] out_id;
    logic [7:0]  out_priority;
    logic [15:0] out_runtime;
    logic [63:0] out_name;

    modport source (output valid, status, out_id, out_priority, out_runtime, out_name,
                    input ready);
    modport sink   (input valid, status, out_id, out_priority, out_runtime, out_name,
                    output ready);
endinterface

FILE: sv/pqd_cell.sv
// One queue slot: holds a record, compares it against the broadcast key and
// shifts in its younger neighbor on removal. Depends on pqd_pkg.
`timescale 1ns / 1ps

module pqd_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pqd_pkg::t_cell_bcast i_bcast,
    input  logic                 i_eligible,
    input  logic                 i_shift,
    input  logic                 i_load,
    input  pqd_pkg::t_rec        i_next,
    output pqd_pkg::t_rec        o_rec,
    output logic                 o_hit
);
    import pqd_pkg::*;

    t_rec r_rec;
    logic r_hit;
    logic n_hit;

    always_comb begin
        case (i_bcast.op)
            OP_POP:      n_hit = i_eligible;
            OP_DEL_ID:   n_hit = i_eligible && (r_rec.id == i_bcast.key_id);
            OP_DEL_NAME: n_hit = i_eligible && (r_rec.name == i_bcast.key_name);
            default:     n_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_bcast.cmp_en) begin
            r_hit <= n_hit;
        end
    end

    // Load and shift never coincide: a push removes nothing.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rec <= i_bcast.load_rec;
        end else if (i_shift) begin
            r_rec <= i_next;
        end
    end

    assign o_rec = r_rec;
    assign o_hit = r_hit;

endmodule

FILE: sv/process_queue_with_delete.sv
// Top level of the process queue with delete by key: controller, cell chain,
// result register and checks. Depends on pqd_pkg, pqd_if and pqd_cell.
`timescale 1ns / 1ps

// Bounded FIFO of process records (id, priority, runtime, name tag) held in a
// chain of QUEUE_DEPTH cells, cell 0 being the head. Each input transfer is one
// operation (push, pop, delete by id, delete by name) and gives exactly one
// result transfer: status ok with the removed record (zero fields for a push),
// or status miss (empty or no match) or full (push dropped) with zero record
// fields. A delete removes the oldest match, head included, and the younger
// cells shift one step toward the head, so order is kept. A pop or delete
// steps through accept, parallel compare in all cells, then find-first and
// shift; a push through accept, then load at the tail. The last step waits
// while the previous result still sits unclaimed in the output register. A new
// operation is taken while a finished result waits to be claimed. Name tags
// keep only their low NAME_BYTES bytes, on push and on compare.
module process_queue_with_delete #(
    parameter int QUEUE_DEPTH = 16,
    parameter int NAME_BYTES  = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pqd_in_if.sink     i_in,
    pqd_out_if.source  o_out
);
    import pqd_pkg::*;

    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [63:0] NAME_MASK = (NAME_BYTES >= 8) ? {64{1'b1}}
                                      : ((64'd1 << (8 * NAME_BYTES)) - 64'd1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [OCC_W-1:0] r_occ, n_occ;

    // latched operation
    logic [1:0]  r_op;
    t_rec        r_key;

    // result register
    logic        r_out_valid;
    logic [1:0]  r_status;
    t_rec        r_out_rec;

    t_cell_bcast             bcast;
    t_rec [QUEUE_DEPTH-1:0]  cell_rec;
    t_rec [QUEUE_DEPTH-1:0]  cell_next;
    logic [QUEUE_DEPTH-1:0]  hit, eligible, shift, load;
    logic [QUEUE_DEPTH-1:0]  hit_prefix, first_hit;
    logic                    any_hit, full, exec_fire, in_fire;
    t_rec                    sel_rec;

    assign in_fire   = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign full      = (r_occ == OCC_W'(QUEUE_DEPTH));
    // execute only when the result register is free or being drained
    assign exec_fire = (r_state == S_EXEC) && (!r_out_valid || o_out.ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (in_fire) n_state = (i_in.opcode == OP_PUSH) ? S_EXEC : S_CMP;
            S_CMP:   n_state = S_EXEC;
            S_EXEC:  if (exec_fire) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op             <= i_in.opcode;
            r_key.id         <= i_in.proc_id;
            r_key.priority_v <= i_in.proc_priority;
            r_key.runtime    <= i_in.proc_runtime;
            r_key.name       <= i_in.proc_name & NAME_MASK;
        end
    end

    assign bcast.cmp_en   = (r_state == S_CMP);
    assign bcast.op       = r_op;
    assign bcast.key_id   = r_key.id;
    assign bcast.key_name = r_key.name;
    assign bcast.load_rec = r_key;

    // inclusive prefix OR of the hit vector: cell i shifts when an
    // older-or-equal cell is removed
    always_comb begin
        hit_prefix = hit;
        for (int s = 1; s < QUEUE_DEPTH; s = s * 2) begin
            hit_prefix = hit_prefix | (hit_prefix << s);
        end
    end
    assign first_hit = hit & ~(hit_prefix << 1);
    assign any_hit   = |hit;

    always_comb begin
        sel_rec = '0;
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            if (first_hit[k]) sel_rec = sel_rec | cell_rec[k];
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
            // pop matches only the head; deletes look at every occupied slot
            assign eligible[gi] = (OCC_W'(gi) < r_occ) && ((r_op != OP_POP) || (gi == 0));
            assign shift[gi]    = exec_fire && (r_op != OP_PUSH) && hit_prefix[gi];
            assign load[gi]     = exec_fire && (r_op == OP_PUSH) && !full
                                  && (r_occ == OCC_W'(gi));
            if (gi == QUEUE_DEPTH - 1) begin : g_tail
                // shifted into a slot that becomes free: contents unused
                assign cell_next[gi] = cell_rec[gi];
            end else begin : g_body
                assign cell_next[gi] = cell_rec[gi+1];
            end

            pqd_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_bcast    (bcast),
                .i_eligible (eligible[gi]),
                .i_shift    (shift[gi]),
                .i_load     (load[gi]),
                .i_next     (cell_next[gi]),
                .o_rec      (cell_rec[gi]),
                .o_hit      (hit[gi])
            );
        end
    endgenerate

    always_comb begin
        n_occ = r_occ;
        if (exec_fire) begin
            if (r_op == OP_PUSH) begin
                if (!full) n_occ = r_occ + OCC_W'(1);
            end else if (any_hit) begin
                n_occ = r_occ - OCC_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_occ <= n_occ;
            if (exec_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_fire) begin
            if (r_op == OP_PUSH) begin
                r_status  <= full ? ST_FULL : ST_OK;
                r_out_rec <= '0;
            end else if (any_hit) begin
                r_status  <= ST_OK;
                r_out_rec <= sel_rec;
            end else begin
                r_status  <= ST_MISS;
                r_out_rec <= '0;
            end
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_status;
    assign o_out.out_id       = r_out_rec.id;
    assign o_out.out_priority = r_out_rec.priority_v;
    assign o_out.out_runtime  = r_out_rec.runtime;
    assign o_out.out_name     = r_out_rec.name;

    // checks
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OCC_W'(QUEUE_DEPTH))
        else $error("occupancy above depth");

    a_first_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> $onehot0(first_hit))
        else $error("more than one cell selected");

    a_remove_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exec_fire && (r_op != OP_PUSH) && any_hit) |=> (r_occ == $past(r_occ) - OCC_W'(1)))
        else $error("removal did not shrink the queue");

    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exec_fire && (r_op == OP_PUSH) && full)
            |=> (r_occ == $past(r_occ) && r_status == ST_FULL))
        else $error("push to full queue changed state");

endmodule
